// File: rtl/core/nppce_pkg.sv
// Shared types and constants for the game pad poller with change events.
package nppce_pkg;

    localparam int BUTTON_COUNT_DEF = 8;
    localparam int BUTTON_IDX_W     = 4;
    localparam int PHASE_W          = 16;

    typedef enum logic [2:0] {
        PH_STROBE_HI = 3'd0,
        PH_STROBE_LO = 3'd1,
        PH_WAIT      = 3'd2,
        PH_CLK_HI    = 3'd3,
        PH_CLK_LO    = 3'd4,
        PH_EVENT     = 3'd5
    } t_phase;

    typedef struct packed {
        logic                    strobe_level;
        logic                    clock_level;
        logic                    event_valid;
        logic                    event_pressed;
        logic [BUTTON_IDX_W-1:0] event_button;
    } t_result;

endpackage

// File: rtl/core/nppce_in_stage.sv
// Input register for the tick items: holds one data line sample until the core takes it.
module nppce_in_stage (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_data_line,
    input  logic i_take,
    output logic o_valid,
    output logic o_data_line
);

    logic r_valid;
    logic r_data;

    assign o_ready     = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_data_line = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data_line;
        end
    end

endmodule

// File: rtl/core/nppce_poll_core.sv
// Poll sequencer: phase state, shift register, change scan and the per-tick result.
module nppce_poll_core #(
    parameter int BUTTON_COUNT = nppce_pkg::BUTTON_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_data_line,
    input  logic [nppce_pkg::PHASE_W-1:0]  i_phase_ticks,
    output nppce_pkg::t_result             o_result
);
    import nppce_pkg::*;

    localparam int CNT_W = $clog2(BUTTON_COUNT + 1);

    t_phase                  r_phase, n_phase;
    logic [PHASE_W-1:0]      r_tick, n_tick;
    logic [CNT_W-1:0]        r_bit, n_bit;
    logic [BUTTON_COUNT-1:0] r_shift, n_shift;
    logic [BUTTON_COUNT-1:0] r_last, n_last;
    logic [BUTTON_IDX_W-1:0] r_scan, n_scan;

    logic [BUTTON_COUNT-1:0] diff;
    logic [BUTTON_COUNT-1:0] diff_sh;
    logic [BUTTON_COUNT-1:0] shift_sh;
    logic [BUTTON_IDX_W:0]   scan_start;
    logic                    scan_found;
    logic [BUTTON_IDX_W-1:0] scan_idx;
    logic                    tick_last;
    logic                    do_scan;
    logic [CNT_W-1:0]        bit_inc;

    assign diff      = r_shift ^ r_last;
    assign diff_sh   = diff >> r_scan;
    assign shift_sh  = r_shift >> r_scan;
    assign tick_last = !(({1'b0, r_tick} + (PHASE_W+1)'(1)) < {1'b0, i_phase_ticks});
    assign bit_inc   = r_bit + CNT_W'(1);

    // Lowest changed bit at or above the scan start; the scan resumes one past the last event.
    assign scan_start = (r_phase == PH_EVENT) ? ({1'b0, r_scan} + (BUTTON_IDX_W+1)'(1))
                                              : '0;

    always_comb begin
        scan_found = 1'b0;
        scan_idx   = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (diff[i] && ((BUTTON_IDX_W+1)'(i) >= scan_start)) begin
                scan_found = 1'b1;
                scan_idx   = BUTTON_IDX_W'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_last  = r_last;
        n_scan  = r_scan;
        do_scan = 1'b0;

        // The pad drives active low, so the sample is inverted on the way in.
        if (r_phase == PH_WAIT && r_tick == '0) begin
            n_shift = (r_shift << 1) | BUTTON_COUNT'(!i_data_line);
        end

        if (!tick_last) begin
            n_tick = r_tick + PHASE_W'(1);
        end else begin
            n_tick = '0;
            case (r_phase)
                PH_STROBE_LO: begin
                    n_bit   = '0;
                    n_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    n_phase = PH_CLK_HI;
                end
                PH_CLK_HI: begin
                    n_phase = PH_CLK_LO;
                end
                PH_CLK_LO: begin
                    n_bit = bit_inc;
                    if (bit_inc >= CNT_W'(BUTTON_COUNT)) begin
                        do_scan = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_EVENT: begin
                    do_scan = 1'b1;
                end
                default: begin
                    n_phase = PH_STROBE_LO;
                end
            endcase
        end

        if (do_scan) begin
            if (scan_found) begin
                n_scan  = scan_idx;
                n_phase = PH_EVENT;
            end else begin
                n_last  = r_shift;
                n_shift = '0;
                n_scan  = '0;
                n_bit   = '0;
                n_phase = PH_STROBE_HI;
            end
        end
    end

    // Pin levels and event for this tick.
    always_comb begin
        o_result = '0;
        case (r_phase)
            PH_STROBE_LO, PH_WAIT, PH_CLK_LO: begin
                o_result = '0;
            end
            PH_CLK_HI: begin
                o_result.clock_level = 1'b1;
            end
            PH_EVENT: begin
                if (r_tick == '0) begin
                    o_result.event_valid   = 1'b1;
                    o_result.event_pressed = shift_sh[0];
                    o_result.event_button  = r_scan;
                end
            end
            default: begin
                o_result.strobe_level = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STROBE_HI;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_last  <= '0;
            r_scan  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_last  <= n_last;
            r_scan  <= n_scan;
        end
    end

    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.strobe_level && o_result.clock_level))
        else $error("strobe and clock driven high together");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= CNT_W'(BUTTON_COUNT))
        else $error("bit count beyond button count");

    a_event_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EVENT) |-> (diff_sh[0] && ({1'b0, r_scan} < (BUTTON_IDX_W+1)'(BUTTON_COUNT))))
        else $error("event phase on a button that did not change");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && do_scan && !scan_found) |=> (r_shift == '0 && r_bit == '0))
        else $error("new poll did not start from a clear shift register");

endmodule

// File: rtl/core/nppce_out_stage.sv
// Result register: holds one result item until the consumer takes it.
module nppce_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  nppce_pkg::t_result i_result,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output nppce_pkg::t_result o_result
);
    import nppce_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/core/nes_pad_poll_change_events.sv
// Top level: game pad poller that turns button changes into event items.
// Throughput: one tick item per cycle, set by the single-pass core between two registers,
// as long as the result register can load; a held result stalls the core.
// The input and result registers let a new item in while a result waits to be taken.
// Synchronous active-low reset: poll restarts at strobe high, status clears, phase length 1.
module nes_pad_poll_change_events #(
    parameter int BUTTON_COUNT = nppce_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_data_line,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_strobe_level,
    output logic                                o_clock_level,
    output logic                                o_event_valid,
    output logic                                o_event_pressed,
    output logic [nppce_pkg::BUTTON_IDX_W-1:0]  o_event_button,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nppce_pkg::PHASE_W-1:0]       i_cfg_data
);
    import nppce_pkg::*;

    logic               r_phase_ticks;
    logic [PHASE_W-1:0] r_phase_len;
    logic               in_valid;
    logic               in_data;
    logic               out_can_load;
    logic               step;
    t_result            core_result;
    t_result            out_result;

    assign o_cfg_ready = 1'b1;

    // r_phase_ticks marks that the phase length register has been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= 1'b0;
            r_phase_len   <= PHASE_W'(1);
        end else if (i_cfg_valid) begin
            r_phase_ticks <= 1'b1;
            r_phase_len   <= i_cfg_data;
        end
    end

    assign step = in_valid && out_can_load;

    nppce_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_line (i_data_line),
        .i_take      (step),
        .o_valid     (in_valid),
        .o_data_line (in_data)
    );

    nppce_poll_core #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_data_line   (in_data),
        .i_phase_ticks (r_phase_len),
        .o_result      (core_result)
    );

    nppce_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_strobe_level  = out_result.strobe_level;
    assign o_clock_level   = out_result.clock_level;
    assign o_event_valid   = out_result.event_valid;
    assign o_event_pressed = out_result.event_pressed;
    assign o_event_button  = out_result.event_button;

    a_len_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_phase_ticks |-> (r_phase_len == PHASE_W'(1)))
        else $error("phase length changed without a write");

    a_step_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("processed item produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_valid && (!o_valid || i_ready)) |=> !o_valid)
        else $error("result appeared without an item");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the game pad poller that turns button changes into events.
`timescale 1ns / 100ps

module tb_top;
    import nppce_pkg::*;

    localparam int NBTN       = BUTTON_COUNT_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 6;

    localparam logic [15:0] BTN_MASK = 16'((32'd1 << NBTN) - 1);

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_data_line = 1'b1;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic                    o_strobe_level;
    logic                    o_clock_level;
    logic                    o_event_valid;
    logic                    o_event_pressed;
    logic [BUTTON_IDX_W-1:0] o_event_button;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [PHASE_W-1:0]      i_cfg_data = '0;

    nes_pad_poll_change_events dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_line     (i_data_line),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_strobe_level  (o_strobe_level),
        .o_clock_level   (o_clock_level),
        .o_event_valid   (o_event_valid),
        .o_event_pressed (o_event_pressed),
        .o_event_button  (o_event_button),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Poller state as the block should hold it.
    t_phase      ph           = PH_STROBE_HI;
    logic [15:0] tick_cnt     = '0;
    logic [4:0]  bit_cnt      = '0;
    logic [15:0] shift_bits   = '0;
    logic [15:0] last_buttons = '0;
    logic [4:0]  scan_idx     = '0;
    logic [31:0] phase_len    = 32'd1;

    t_result     pin_results_due[$];
    logic [15:0] pad_target = '0;
    int          mismatches = 0;
    int          cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Find the next changed button at or above 'from', or commit the status.
    function automatic void scan_changes(input int from);
        logic [15:0] diff;
        diff = (shift_bits ^ last_buttons) & BTN_MASK;
        for (int i = from; i < NBTN && i < 16; i++) begin
            if (diff[i]) begin
                scan_idx = 5'(i);
                ph = PH_EVENT;
                return;
            end
        end
        last_buttons = shift_bits & BTN_MASK;
        shift_bits = '0;
        scan_idx = '0;
        bit_cnt = '0;
        ph = PH_STROBE_HI;
    endfunction

    function automatic t_result poll_tick(input logic data);
        t_result r;
        t_phase  cur;
        r = '0;
        cur = ph;
        case (cur)
            PH_STROBE_HI: r.strobe_level = 1'b1;
            PH_CLK_HI:    r.clock_level = 1'b1;
            PH_WAIT: begin
                if (tick_cnt == 0)
                    shift_bits = ((shift_bits << 1) | {15'd0, ~data}) & BTN_MASK;
            end
            PH_EVENT: begin
                if (tick_cnt == 0) begin
                    r.event_valid   = 1'b1;
                    r.event_button  = scan_idx[BUTTON_IDX_W-1:0];
                    r.event_pressed = shift_bits[scan_idx[3:0]];
                end
            end
            default: ;
        endcase
        if ({16'd0, tick_cnt} + 32'd1 < phase_len) begin
            tick_cnt = tick_cnt + 16'd1;
        end else begin
            tick_cnt = '0;
            case (cur)
                PH_STROBE_HI: ph = PH_STROBE_LO;
                PH_STROBE_LO: begin
                    bit_cnt = '0;
                    ph = PH_WAIT;
                end
                PH_WAIT:   ph = PH_CLK_HI;
                PH_CLK_HI: ph = PH_CLK_LO;
                PH_CLK_LO: begin
                    bit_cnt = bit_cnt + 5'd1;
                    if (bit_cnt >= NBTN)
                        scan_changes(0);
                    else
                        ph = PH_WAIT;
                end
                default: scan_changes(int'(scan_idx) + 1);
            endcase
        end
        return r;
    endfunction

    // Every task below starts and ends just after a rising edge.
    task automatic send_tick(input logic data);
        i_valid <= 1'b1;
        i_data_line <= data;
        do @(posedge i_clk); while (!o_ready);
        pin_results_due.push_back(poll_tick(data));
    endtask

    task automatic hold_off(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pin_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_phase_len(input logic [15:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        phase_len = {16'd0, value};
    endtask

    // Drive the pad from a target status during sampling ticks, with some noise.
    function automatic logic pad_level();
        int pick;
        if (ph == PH_STROBE_HI && tick_cnt == 0) begin
            pick = $urandom_range(0, 7);
            case (pick)
                3, 4:    pad_target[$urandom_range(0, NBTN - 1)] ^= 1'b1;
                5:       pad_target = 16'($urandom) & BTN_MASK;
                6:       pad_target = BTN_MASK;
                7:       pad_target = '0;
                default: ;
            endcase
        end
        if ($urandom_range(0, 9) == 0 || ph != PH_WAIT)
            return 1'($urandom_range(0, 1));
        return ~pad_target[NBTN - 1 - int'(bit_cnt)];
    endfunction

    task automatic test_press_all();
        repeat (34) send_tick(1'b0);
        hold_off(3);
    endtask

    task automatic test_zero_phase_release_all();
        write_phase_len(16'd0);
        repeat (34) send_tick(1'b1);
    endtask

    // A shorter phase written mid-phase must end the running phase at once.
    task automatic test_phase_len_change();
        write_phase_len(16'hFFFF);
        repeat (12) send_tick(1'($urandom_range(0, 1)));
        write_phase_len(16'd3);
        repeat (12) send_tick(1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_polls();
        int sent;
        int seg_left;
        int burst_left;
        int gap;
        logic [15:0] len;
        sent = 0;
        while (sent < 1000) begin
            case ($urandom_range(0, 7))
                0:       len = 16'd0;
                1, 2:    len = 16'd1;
                3:       len = 16'd2;
                4:       len = 16'd3;
                default: len = 16'($urandom_range(1, 5));
            endcase
            write_phase_len(len);
            seg_left = $urandom_range(80, 220);
            burst_left = $urandom_range(1, 40);
            while (seg_left > 0) begin
                send_tick(pad_level());
                sent++;
                seg_left--;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 29) == 0)
                        wait_drained();
                    else if (gap > 0)
                        hold_off(gap);
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_press_all();
        test_zero_phase_release_all();
        test_phase_len_change();
        test_random_polls();
        wait_drained();
        if (mismatches == 0 && pin_results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver stalls in modes: always ready, random, periodic and mostly stalled.
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 100);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            2:       i_ready <= (cycles % 5) < 3;
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pin_results_due.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %b%b%b%b%h",
                         $time, o_strobe_level, o_clock_level, o_event_valid,
                         o_event_pressed, o_event_button);
                mismatches++;
            end else begin
                want = pin_results_due.pop_front();
                check_field("strobe_level", want.strobe_level, o_strobe_level);
                check_field("clock_level", want.clock_level, o_clock_level);
                check_field("event_valid", want.event_valid, o_event_valid);
                check_field("event_pressed", want.event_pressed, o_event_pressed);
                check_field("event_button", want.event_button, o_event_button);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// File: nes_pad_poll_change_events.f
rtl/core/nppce_pkg.sv
rtl/core/nppce_in_stage.sv
rtl/core/nppce_poll_core.sv
rtl/core/nppce_out_stage.sv
rtl/core/nes_pad_poll_change_events.sv
tb/tb_top.sv
